// ----- hdl/cbsr_pkg.sv -----
`default_nettype none
package cbsr_pkg;

    // Sample count per whole segment
    localparam int SAMPLES = 32;

    localparam int CW        = 24;                       // coordinate width
    localparam int CNT_W     = $clog2(SAMPLES + 1);      // sample index width
    localparam int REM_W     = $clog2(SAMPLES);          // t remainder width
    localparam int T_W       = 17;                       // t in [0, 65536]
    localparam int RECIP_K   = 24;
    localparam int RECIP     = (1 << RECIP_K) / SAMPLES;
    localparam int LW        = 27;                       // lerp lane width
    localparam int PW        = LW + 1 + T_W + 1;         // lerp product width
    localparam int LANES     = 10;
    localparam int AW        = 26;                       // tangent magnitude width
    localparam int NORM_BIT  = 20;
    localparam int SQ_W      = 2 * AW;
    localparam int RAD_W     = 54;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int ROOT_ITERS = ROOT_W;
    localparam int RREM_W    = ROOT_W + 2;
    localparam int DIV_Q     = 18;
    localparam int NUM_W     = AW + 17 + 1;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int GSQ_W     = 2 * (CW + 1);
    localparam int ITER_W    = 5;
    localparam logic [GSQ_W:0] GAP_LIMIT = (GSQ_W + 1)'(1600 * 65536);
    localparam logic [15:0] PARTIAL_MIN = 16'd66;
    localparam logic [15:0] STROKE_RESET = 16'd256;

    // Register indexes
    localparam logic REG_PEN_WIDTH = 1'b0;

    typedef struct packed {
        logic signed [CW-1:0] ctrl0_x;
        logic signed [CW-1:0] ctrl0_y;
        logic signed [CW-1:0] ctrl1_x;
        logic signed [CW-1:0] ctrl1_y;
        logic signed [CW-1:0] ctrl2_x;
        logic signed [CW-1:0] ctrl2_y;
        logic signed [CW-1:0] ctrl3_x;
        logic signed [CW-1:0] ctrl3_y;
        logic                 negative_winding;
        logic [15:0]          partial_fraction;
        logic                 first_segment;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] d_x;
        logic signed [CW-1:0] d_y;
        logic                 join_only;
        logic                 last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_LMUL, ST_LADD, ST_NINIT, ST_NORM, ST_SQR,
        ST_RINIT, ST_ROOT, ST_DMUL, ST_DIV, ST_FIN, ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       lmul;
        logic       ladd;
        logic [1:0] level;
        logic       norm_init;
        logic       norm_step;
        logic       sq;
        logic       root_init;
        logic       root_step;
        logic       dmul;
        logic       div_step;
        logic       fin;
        logic       emit;
        logic       next;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_width;
        logic tan_zero;
        logic norm_done;
        logic last_sample;
        logic out_free;
    } dp_stat_t;

    // a + round((b - a) * t / 65536), product already formed
    function automatic logic signed [LW-1:0] lerp_fin(input logic signed [LW-1:0] a,
                                                      input logic signed [PW-1:0] prod);
        logic signed [PW-1:0] w;
        w = prod + PW'(32768);
        w = w >>> 16;
        return a + w[LW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sat24(input logic signed [CW+1:0] v);
        if (v > (CW+2)'(signed'(24'sh7FFFFF)))
            return 24'sh7FFFFF;
        else if (v < (CW+2)'(signed'(24'sh800000)))
            return 24'sh800000;
        else
            return v[CW-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/cbsr_datapath.sv -----
`default_nettype none
module cbsr_datapath
    import cbsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire in_item_t    s_item,
    input  wire logic [15:0] pen_width,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output out_item_t        m_item,
    output logic             m_valid,
    input  wire logic        m_ready
);

    // Segment registers
    logic signed [CW-1:0]   px_reg [4];
    logic signed [CW-1:0]   py_reg [4];
    logic signed [CW:0]     dx_reg [3];
    logic signed [CW:0]     dy_reg [3];
    logic                   neg_reg, first_reg;
    logic [T_W-1:0]         step_reg, qest_reg, q0_reg;
    logic [REM_W-1:0]       r0_reg, rem_reg;
    logic [CNT_W-1:0]       end_n_reg, idx_reg;
    logic [T_W-1:0]         t_reg;

    // Lerp lanes
    logic signed [LW-1:0]   lane_a [LANES];
    logic signed [LW-1:0]   lane_b [LANES];
    logic [LANES-1:0]       lane_we;
    logic signed [LW-1:0]   mula_reg [LANES];
    logic signed [PW-1:0]   prod_reg [LANES];
    logic signed [LW-1:0]   res_reg [LANES];

    // Normal unit
    logic [AW-1:0]          ax_reg, ay_reg;
    logic                   tz_reg;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [RAD_W-1:0]       rad_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [RREM_W-1:0]      rrem_reg;
    logic [DEN_W-1:0]       rx_reg, ry_reg;
    logic [DIV_Q-1:0]       nlx_reg, nly_reg;
    logic signed [CW-1:0]   ox_reg, oy_reg;
    logic [GSQ_W-1:0]       gx_reg, gy_reg;

    // Path state
    logic signed [CW-1:0]   pcx_reg, pcy_reg, pox_reg, poy_reg;
    logic                   have_prev_reg;
    out_item_t              out_reg;
    logic                   out_valid_reg;

    // Load-time arithmetic
    logic                   partial;
    logic [T_W-1:0]         step_next;
    logic [47:0]            qprod;
    logic [31:0]            en_sum;
    logic [CNT_W-1:0]       en_val;
    always_comb begin
        partial   = s_item.partial_fraction >= PARTIAL_MIN;
        step_next = partial ? {1'b0, s_item.partial_fraction} : T_W'(65536);
        qprod     = 48'(step_next) * 48'(RECIP);
        en_sum    = 32'(s_item.partial_fraction) * 32'(SAMPLES) + 32'd32768;
        en_val    = en_sum[16 +: CNT_W];
        if (!partial)
            en_val = CNT_W'(SAMPLES);
        else if (en_val == '0)
            en_val = CNT_W'(1);
    end

    // Step quotient correction
    logic [23:0] qs, rfull;
    always_comb begin
        qs    = 24'(qest_reg) * 24'(SAMPLES);
        rfull = 24'(step_reg) - qs;
    end

    // t advance
    logic [REM_W:0] rsum;
    assign rsum = {1'b0, rem_reg} + {1'b0, r0_reg};

    // Lane operand selection per de Casteljau level
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            lane_a[k] = res_reg[k];
            lane_b[k] = res_reg[k];
        end
        lane_we = '0;
        case (cmd.level)
            2'd0: begin
                for (int k = 0; k < 3; k++) begin
                    lane_a[k]   = LW'(px_reg[k]);
                    lane_b[k]   = LW'(px_reg[k+1]);
                    lane_a[k+5] = LW'(py_reg[k]);
                    lane_b[k+5] = LW'(py_reg[k+1]);
                end
                for (int k = 0; k < 2; k++) begin
                    lane_a[k+3] = LW'(dx_reg[k]);
                    lane_b[k+3] = LW'(dx_reg[k+1]);
                    lane_a[k+8] = LW'(dy_reg[k]);
                    lane_b[k+8] = LW'(dy_reg[k+1]);
                end
                lane_we = '1;
            end
            2'd1: begin
                for (int h = 0; h < 2; h++) begin
                    lane_a[5*h]   = res_reg[5*h];
                    lane_b[5*h]   = res_reg[5*h+1];
                    lane_a[5*h+1] = res_reg[5*h+1];
                    lane_b[5*h+1] = res_reg[5*h+2];
                    lane_a[5*h+2] = res_reg[5*h+3];
                    lane_b[5*h+2] = res_reg[5*h+4];
                end
                lane_we = LANES'(10'b00111_00111);
            end
            2'd2: begin
                for (int h = 0; h < 2; h++) begin
                    lane_a[5*h] = res_reg[5*h];
                    lane_b[5*h] = res_reg[5*h+1];
                end
                lane_we = LANES'(10'b00001_00001);
            end
            default: begin
                lane_we = '0;
            end
        endcase
    end

    // Tangent magnitudes
    logic [LW-1:0] abs_tx, abs_ty;
    logic          tx_neg, ty_pos;
    always_comb begin
        abs_tx = res_reg[2][LW-1] ? LW'(-res_reg[2]) : LW'(res_reg[2]);
        abs_ty = res_reg[7][LW-1] ? LW'(-res_reg[7]) : LW'(res_reg[7]);
        tx_neg = res_reg[2][LW-1];
        ty_pos = !res_reg[7][LW-1] && (res_reg[7] != '0);
    end

    // Square root step
    logic [RREM_W+1:0] rr_t, rr_trial;
    always_comb begin
        rr_t     = {rrem_reg, rad_reg[RAD_W-1 -: 2]};
        rr_trial = {1'b0, root_reg, 2'b01};
    end

    // Divider step, both normal components together
    logic [16:0]       hw2;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  numx, numy;
    logic [DEN_W:0]    r2x, r2y;
    always_comb begin
        hw2  = 17'(pen_width) + 17'd256;
        den  = {root_reg, 1'b0};
        numx = NUM_W'(ay_reg) * NUM_W'(hw2) + NUM_W'(root_reg);
        numy = NUM_W'(ax_reg) * NUM_W'(hw2) + NUM_W'(root_reg);
        r2x  = {rx_reg, nlx_reg[DIV_Q-1]};
        r2y  = {ry_reg, nly_reg[DIV_Q-1]};
    end

    // Offset points and gap distance
    logic signed [CW-1:0]   cx, cy;
    logic signed [DIV_Q:0]  nx, ny;
    logic signed [CW:0]     gdx, gdy;
    logic [GSQ_W:0]         gsum;
    logic                   silent;
    always_comb begin
        cx = res_reg[0][CW-1:0];
        cy = res_reg[5][CW-1:0];
        nx = ty_pos ? -$signed({1'b0, nlx_reg}) : $signed({1'b0, nlx_reg});
        ny = tx_neg ? -$signed({1'b0, nly_reg}) : $signed({1'b0, nly_reg});
        if (neg_reg) begin
            nx = -nx;
            ny = -ny;
        end
        if (tz_reg) begin
            nx = '0;
            ny = '0;
        end
        gdx    = (CW+1)'(cx) - (CW+1)'(pcx_reg);
        gdy    = (CW+1)'(cy) - (CW+1)'(pcy_reg);
        gsum   = (GSQ_W+1)'(gx_reg) + (GSQ_W+1)'(gy_reg);
        silent = (idx_reg == '0) && (first_reg || !have_prev_reg || gsum > GAP_LIMIT);
    end

    // Payload and arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg[0] <= s_item.ctrl0_x; py_reg[0] <= s_item.ctrl0_y;
            px_reg[1] <= s_item.ctrl1_x; py_reg[1] <= s_item.ctrl1_y;
            px_reg[2] <= s_item.ctrl2_x; py_reg[2] <= s_item.ctrl2_y;
            px_reg[3] <= s_item.ctrl3_x; py_reg[3] <= s_item.ctrl3_y;
            dx_reg[0] <= (CW+1)'(s_item.ctrl1_x) - (CW+1)'(s_item.ctrl0_x);
            dx_reg[1] <= (CW+1)'(s_item.ctrl2_x) - (CW+1)'(s_item.ctrl1_x);
            dx_reg[2] <= (CW+1)'(s_item.ctrl3_x) - (CW+1)'(s_item.ctrl2_x);
            dy_reg[0] <= (CW+1)'(s_item.ctrl1_y) - (CW+1)'(s_item.ctrl0_y);
            dy_reg[1] <= (CW+1)'(s_item.ctrl2_y) - (CW+1)'(s_item.ctrl1_y);
            dy_reg[2] <= (CW+1)'(s_item.ctrl3_y) - (CW+1)'(s_item.ctrl2_y);
            neg_reg   <= s_item.negative_winding;
            first_reg <= s_item.first_segment;
            step_reg  <= step_next;
            qest_reg  <= qprod[RECIP_K +: T_W];
            end_n_reg <= en_val;
        end
        if (cmd.prep) begin
            if (rfull >= 24'(SAMPLES)) begin
                q0_reg <= qest_reg + T_W'(1);
                r0_reg <= REM_W'(rfull - 24'(SAMPLES));
            end else begin
                q0_reg <= qest_reg;
                r0_reg <= REM_W'(rfull);
            end
            t_reg   <= '0;
            rem_reg <= REM_W'(SAMPLES / 2);
            idx_reg <= '0;
        end
        if (cmd.next) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (rsum >= (REM_W+1)'(SAMPLES)) begin
                rem_reg <= REM_W'(rsum - (REM_W+1)'(SAMPLES));
                t_reg   <= t_reg + q0_reg + T_W'(1);
            end else begin
                rem_reg <= rsum[REM_W-1:0];
                t_reg   <= t_reg + q0_reg;
            end
        end
        // lerp multiply, then round and add
        if (cmd.lmul) begin
            for (int k = 0; k < LANES; k++) begin
                mula_reg[k] <= lane_a[k];
                prod_reg[k] <= PW'(($signed({lane_b[k][LW-1], lane_b[k]})
                               - $signed({lane_a[k][LW-1], lane_a[k]}))
                               * $signed({1'b0, t_reg}));
            end
        end
        if (cmd.ladd) begin
            for (int k = 0; k < LANES; k++) begin
                if (lane_we[k])
                    res_reg[k] <= lerp_fin(mula_reg[k], prod_reg[k]);
            end
        end
        // tangent normalisation
        if (cmd.norm_init) begin
            ax_reg <= abs_tx[AW-1:0];
            ay_reg <= abs_ty[AW-1:0];
            tz_reg <= (res_reg[2] == '0) && (res_reg[7] == '0);
        end
        if (cmd.norm_step) begin
            ax_reg <= {ax_reg[AW-2:0], 1'b0};
            ay_reg <= {ay_reg[AW-2:0], 1'b0};
        end
        if (cmd.sq) begin
            sqx_reg <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqy_reg <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        end
        // integer square root, one bit a cycle
        if (cmd.root_init) begin
            rad_reg  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            root_reg <= '0;
            rrem_reg <= '0;
        end
        if (cmd.root_step) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rr_t >= rr_trial) begin
                rrem_reg <= RREM_W'(rr_t - rr_trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rrem_reg <= RREM_W'(rr_t);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        // restoring division, quotient shifts into the low word
        if (cmd.dmul) begin
            rx_reg  <= DEN_W'(numx[NUM_W-1:DIV_Q]);
            ry_reg  <= DEN_W'(numy[NUM_W-1:DIV_Q]);
            nlx_reg <= numx[DIV_Q-1:0];
            nly_reg <= numy[DIV_Q-1:0];
        end
        if (cmd.div_step) begin
            if (r2x >= (DEN_W+1)'(den)) begin
                rx_reg  <= DEN_W'(r2x - (DEN_W+1)'(den));
                nlx_reg <= {nlx_reg[DIV_Q-2:0], 1'b1};
            end else begin
                rx_reg  <= DEN_W'(r2x);
                nlx_reg <= {nlx_reg[DIV_Q-2:0], 1'b0};
            end
            if (r2y >= (DEN_W+1)'(den)) begin
                ry_reg  <= DEN_W'(r2y - (DEN_W+1)'(den));
                nly_reg <= {nly_reg[DIV_Q-2:0], 1'b1};
            end else begin
                ry_reg  <= DEN_W'(r2y);
                nly_reg <= {nly_reg[DIV_Q-2:0], 1'b0};
            end
        end
        if (cmd.fin) begin
            ox_reg <= sat24((CW+2)'(cx) - (CW+2)'(nx));
            oy_reg <= sat24((CW+2)'(cy) - (CW+2)'(ny));
            gx_reg <= GSQ_W'(gdx * gdx);
            gy_reg <= GSQ_W'(gdy * gdy);
        end
        if (cmd.emit && !silent) begin
            out_reg.a_x       <= pcx_reg;
            out_reg.a_y       <= pcy_reg;
            out_reg.b_x       <= pox_reg;
            out_reg.b_y       <= poy_reg;
            out_reg.c_x       <= cx;
            out_reg.c_y       <= cy;
            out_reg.d_x       <= ox_reg;
            out_reg.d_y       <= oy_reg;
            out_reg.join_only <= (idx_reg == '0);
            out_reg.last      <= (idx_reg == end_n_reg);
        end
    end

    // Path state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcx_reg       <= '0;
            pcy_reg       <= '0;
            pox_reg       <= '0;
            poy_reg       <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                pcx_reg       <= cx;
                pcy_reg       <= cy;
                pox_reg       <= ox_reg;
                poy_reg       <= oy_reg;
                have_prev_reg <= 1'b1;
            end
            if (cmd.emit && !silent)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_item  = out_reg;
    assign m_valid = out_valid_reg;

    always_comb begin
        stat.zero_width  = (pen_width == '0);
        stat.tan_zero    = tz_reg;
        stat.norm_done   = ax_reg[AW-1:NORM_BIT] != '0 || ay_reg[AW-1:NORM_BIT] != '0;
        stat.last_sample = (idx_reg == end_n_reg);
        stat.out_free    = !out_valid_reg || m_ready;
    end

endmodule
`default_nettype wire

// ----- hdl/cbsr_ctrl.sv -----
`default_nettype none
module cbsr_ctrl
    import cbsr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t         state_reg, state_next;
    logic [1:0]          level_reg, level_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            iter_reg  <= iter_next;
        end
    end

    // Sequencing: load and prep a segment, then per sample lerp levels, normalise, root, divide, emit
    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.level  = level_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (!stat.zero_width)
                        state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                level_next = '0;
                state_next = ST_LMUL;
            end
            ST_LMUL: begin
                cmd.lmul   = 1'b1;
                state_next = ST_LADD;
            end
            ST_LADD: begin
                cmd.ladd = 1'b1;
                if (level_reg == 2'd2) begin
                    state_next = ST_NINIT;
                end else begin
                    level_next = level_reg + 2'd1;
                    state_next = ST_LMUL;
                end
            end
            ST_NINIT: begin
                cmd.norm_init = 1'b1;
                state_next    = ST_NORM;
            end
            ST_NORM: begin
                if (stat.tan_zero)
                    state_next = ST_FIN;
                else if (stat.norm_done)
                    state_next = ST_SQR;
                else
                    cmd.norm_step = 1'b1;
            end
            ST_SQR: begin
                cmd.sq     = 1'b1;
                state_next = ST_RINIT;
            end
            ST_RINIT: begin
                cmd.root_init = 1'b1;
                iter_next     = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                iter_next     = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(ROOT_ITERS - 1))
                    state_next = ST_DMUL;
            end
            ST_DMUL: begin
                cmd.dmul   = 1'b1;
                iter_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DIV_Q - 1))
                    state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.last_sample) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next   = 1'b1;
                        level_next = '0;
                        state_next = ST_LMUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/cubic_bezier_stroke_ribbon.sv -----
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_item (in_item_t): one Bezier segment
// m_        out        m_valid/m_ready    m_item (out_item_t): one quad or join
// apb       in         psel/penable       pen width at address 0
//
// Each sample runs the lerp levels, a normalisation of at most 20 shifts, the
// square root and the divider. A zero tangent skips square, root and divide.
// A segment computes n + 1 samples, n being SAMPLES or the partial count.
// Reset clears the path state and the output slot; the pen width resets to 256.
// s_ready is high only in idle; a stalled output holds the emit step and nothing
// further is computed until the slot frees.
module cubic_bezier_stroke_ribbon
    import cbsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] pen_width_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_width_reg <= STROKE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_PEN_WIDTH) begin
            pen_width_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PEN_WIDTH) ? {16'b0, pen_width_reg} : 32'b0;

    cbsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cbsr_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_item       (s_item),
        .pen_width    (pen_width_reg),
        .cmd          (cmd),
        .stat         (stat),
        .m_item       (m_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule
`default_nettype wire
